### hw/rtl/zcsd_pkg.sv
`timescale 1ns / 1ps
// Shared widths, register codes and sideband types for the z-cylinder side/distance unit.
// No dependencies; used by every RTL file of the block and by its checker.
package zcsd_pkg;

	// Fixed-point formats
	localparam int POS_FRAC_BITS = 16;
	localparam int DIR_FRAC_BITS = 14;

	// Field widths
	localparam int POS_W  = 32;
	localparam int DIR_W  = 16;
	localparam int RAD_W  = 31;
	localparam int TOL_W  = 32;
	localparam int DIST_W = 32;
	localparam int CFG_W  = 32;
	localparam int IDX_W  = 2;

	// Datapath widths
	localparam int D_W    = POS_W + 1;            // position offset from axis
	localparam int SQD_W  = 2 * D_W;              // squared offset
	localparam int S_W    = SQD_W + 1;            // dx^2 + dy^2, also |c|
	localparam int R2_W   = 2 * RAD_W;            // radius^2
	localparam int K_W    = D_W + DIR_W + 1;      // signed dot product k
	localparam int A_W    = 2 * DIR_W;            // |dir|^2
	localparam int KH     = (K_W + 1) / 2;        // half of |k| for split squaring
	localparam int CCH    = (S_W + 2) / 3;        // third of |c| for split product
	localparam int QW     = 2 * K_W + 2;          // discriminant, even width
	localparam int SQ_W   = QW / 2;               // integer square root
	localparam int REM_W  = SQ_W + 3;             // root remainder
	localparam int NUM_W  = SQ_W + 1;             // distance numerator
	localparam int DVD_W  = NUM_W + DIR_FRAC_BITS;
	localparam int HI_W   = DVD_W - DIST_W;       // dividend part above the quotient
	localparam int DREM_W = A_W + 1;              // divider remainder

	// Start-to-strobe latency in clock edges
	localparam int FRONT_STAGES = 9;
	localparam int LATENCY = FRONT_STAGES + SQ_W + 2 + DIST_W + 1;

	localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(1) << POS_FRAC_BITS;
	localparam logic [TOL_W-1:0] TOL_RESET    = TOL_W'(4295);

	// Configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_CENTER_X = 2'd0,
		REG_CENTER_Y = 2'd1,
		REG_RADIUS   = 2'd2,
		REG_TOL      = 2'd3
	} zcsd_reg_t;

	// Per-request sideband carried beside the square root
	typedef struct packed {
		logic             side;
		logic             coinc;
		logic             cneg;
		logic             qok;
		logic             kneg;
		logic             kpos;
		logic [K_W-1:0]   kmag;
		logic [A_W-1:0]   a;
	} zcsd_tag_t;

endpackage

### hw/rtl/zcylinder_side_and_distance_unit.sv
`timescale 1ns / 1ps
// Each accepted start yields a done strobe carrying its result.
// Throughput: one request per cycle; busy stays low, results leave in request order.
// Latency is set by the front pipeline, the 51-stage square root and the 32-stage divider, one bit per stage.
// Reset (arst_n low) clears all valid bits and loads the register defaults:
// center 0, radius 1.0, tolerance 4295. Config writes take effect on the next cycle.
module zcylinder_side_and_distance_unit import zcsd_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic                    cfg_we,
	input  logic [IDX_W-1:0]        cfg_index,
	input  logic [CFG_W-1:0]        cfg_wdata,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	input  logic signed [DIR_W-1:0] dir_x,
	input  logic signed [DIR_W-1:0] dir_y,
	input  logic                    on_surface,
	output logic                    done,
	output logic                    side_positive,
	output logic                    hit,
	output logic [DIST_W-1:0]       hit_distance
);

	logic [POS_W-1:0]  center_x_q, center_y_q;
	logic [RAD_W-1:0]  radius_q;
	logic [TOL_W-1:0]  tol_q;
	logic              f_vld, s_vld, d_vld;
	logic [QW-1:0]     quad;
	zcsd_tag_t         f_tag, s_tag;
	logic [SQ_W-1:0]   root;
	logic              d_side, d_hit;
	logic [DIST_W-1:0] d_dist;
	logic              done_q, side_q, hit_q;
	logic [DIST_W-1:0] dist_q;

	// the pipeline never stalls
	assign busy = 1'b0;

	// hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			radius_q   <= RADIUS_RESET;
			tol_q      <= TOL_RESET;
		end else if (cfg_we) begin
			case (zcsd_reg_t'(cfg_index))
				REG_CENTER_X: center_x_q <= cfg_wdata[POS_W-1:0];
				REG_CENTER_Y: center_y_q <= cfg_wdata[POS_W-1:0];
				REG_RADIUS:   radius_q   <= cfg_wdata[RAD_W-1:0];
				REG_TOL:      tol_q      <= cfg_wdata[TOL_W-1:0];
				default:      ;
			endcase
		end
	end

	zcsd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_vld       (start && !busy),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.dir_x        (dir_x),
		.dir_y        (dir_y),
		.on_surface   (on_surface),
		.center_x     (center_x_q),
		.center_y     (center_y_q),
		.radius       (radius_q),
		.coincide_tol (tol_q),
		.out_vld      (f_vld),
		.quad         (quad),
		.tag          (f_tag)
	);

	zcsd_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (f_vld),
		.quad    (quad),
		.in_tag  (f_tag),
		.out_vld (s_vld),
		.root    (root),
		.out_tag (s_tag)
	);

	zcsd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (s_vld),
		.root     (root),
		.in_tag   (s_tag),
		.out_vld  (d_vld),
		.side     (d_side),
		.hit      (d_hit),
		.hit_dist (d_dist)
	);

	// register results and strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= d_vld;
		end
	end

	always_ff @(posedge clk) begin
		side_q <= d_side;
		hit_q  <= d_hit;
		dist_q <= d_dist;
	end

	assign done          = done_q;
	assign side_positive = side_q;
	assign hit           = hit_q;
	assign hit_distance  = dist_q;

endmodule

### hw/rtl/zcsd_front.sv
`timescale 1ns / 1ps
// Front pipeline: offsets, dot products, residual c, side decision and discriminant.
// Depends on zcsd_pkg.
module zcsd_front import zcsd_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_vld,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	input  logic signed [DIR_W-1:0] dir_x,
	input  logic signed [DIR_W-1:0] dir_y,
	input  logic                    on_surface,
	input  logic [POS_W-1:0]        center_x,
	input  logic [POS_W-1:0]        center_y,
	input  logic [RAD_W-1:0]        radius,
	input  logic [TOL_W-1:0]        coincide_tol,
	output logic                    out_vld,
	output logic [QW-1:0]           quad,
	output zcsd_tag_t               tag
);

	logic [FRONT_STAGES-1:0] vld_q;

	logic signed [D_W-1:0]   dx_s1, dy_s1, dx_s2, dy_s2;
	logic signed [DIR_W-1:0] ux_s1, uy_s1, ux_s2, uy_s2;
	logic                    on_s1, on_s2, on_s3, on_s4, on_s5, on_s6;
	logic [D_W-1:0]          dxm_s2, dym_s2;
	logic [A_W-1:0]          ux2_s2, uy2_s2;
	logic [R2_W-1:0]         r2_s2, r2_s3, r2_s4;
	logic [SQD_W-1:0]        dx2_s3, dy2_s3;
	logic signed [K_W-1:0]   kx_s3, ky_s3, k_s4, k_s5;
	logic [A_W-1:0]          a_s3, a_s4, a_s5, a_s6;
	logic [S_W-1:0]          s_s4;
	logic [S_W:0]            diff_s5, ndiff;
	logic                    cneg_s6, kneg_s6, kpos_s6;
	logic [S_W-1:0]          cmag_s6;
	logic [K_W-1:0]          kmag_s6, nk;
	logic [S_W-1:0]          tolx;
	logic [2*KH-1:0]         kpad;
	logic [3*CCH-1:0]        cpad;
	logic [2*KH-1:0]         pp_hh_s7, pp_hl_s7, pp_ll_s7;
	logic [A_W+CCH-1:0]      ac0_s7, ac1_s7, ac2_s7;
	zcsd_tag_t               tag_s7, tag_s8, tag_s9, tag_nx;
	logic [QW-1:0]           k2_s8, ac_s8, qsum, quad_s9;
	logic [QW:0]             qdiff;

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[FRONT_STAGES-2:0], in_vld};
		end
	end

	assign ndiff = ~diff_s5 + 1'b1;
	assign nk    = ~k_s5 + 1'b1;
	assign tolx  = {{(S_W-TOL_W){1'b0}}, coincide_tol};
	assign kpad  = {{(2*KH-K_W){1'b0}}, kmag_s6};
	assign cpad  = {{(3*CCH-S_W){1'b0}}, cmag_s6};
	assign qsum  = k2_s8 + ac_s8;
	assign qdiff = {1'b0, k2_s8} - {1'b0, ac_s8};

	// clear qok for requests with a negative discriminant, so they report no hit
	always_comb begin
		tag_nx     = tag_s8;
		tag_nx.qok = tag_s8.qok && (tag_s8.cneg || !qdiff[QW]);
	end

	always_ff @(posedge clk) begin
		// s1: offsets from the axis
		dx_s1 <= {pos_x[POS_W-1], pos_x} - {center_x[POS_W-1], center_x};
		dy_s1 <= {pos_y[POS_W-1], pos_y} - {center_y[POS_W-1], center_y};
		ux_s1 <= dir_x;
		uy_s1 <= dir_y;
		on_s1 <= on_surface;

		// s2: magnitudes, direction squares, radius squared
		dxm_s2 <= dx_s1[D_W-1] ? D_W'(~dx_s1 + 1'b1) : dx_s1;
		dym_s2 <= dy_s1[D_W-1] ? D_W'(~dy_s1 + 1'b1) : dy_s1;
		dx_s2  <= dx_s1;
		dy_s2  <= dy_s1;
		ux_s2  <= ux_s1;
		uy_s2  <= uy_s1;
		ux2_s2 <= A_W'(ux_s1) * A_W'(ux_s1);
		uy2_s2 <= A_W'(uy_s1) * A_W'(uy_s1);
		r2_s2  <= R2_W'(radius) * R2_W'(radius);
		on_s2  <= on_s1;

		// s3: offset squares and dot-product terms
		dx2_s3 <= SQD_W'(dxm_s2) * SQD_W'(dxm_s2);
		dy2_s3 <= SQD_W'(dym_s2) * SQD_W'(dym_s2);
		kx_s3  <= K_W'(dx_s2) * K_W'(ux_s2);
		ky_s3  <= K_W'(dy_s2) * K_W'(uy_s2);
		a_s3   <= ux2_s2 + uy2_s2;
		r2_s3  <= r2_s2;
		on_s3  <= on_s2;

		// s4: sums
		s_s4  <= S_W'(dx2_s3) + S_W'(dy2_s3);
		k_s4  <= kx_s3 + ky_s3;
		a_s4  <= a_s3;
		r2_s4 <= r2_s3;
		on_s4 <= on_s3;

		// s5: residual c = s - r^2
		diff_s5 <= {1'b0, s_s4} - {{(S_W+1-R2_W){1'b0}}, r2_s4};
		k_s5    <= k_s4;
		a_s5    <= a_s4;
		on_s5   <= on_s4;

		// s6: magnitudes and signs
		cneg_s6 <= diff_s5[S_W];
		cmag_s6 <= diff_s5[S_W] ? ndiff[S_W-1:0] : diff_s5[S_W-1:0];
		kneg_s6 <= k_s5[K_W-1];
		kpos_s6 <= !k_s5[K_W-1] && (k_s5 != '0);
		kmag_s6 <= k_s5[K_W-1] ? nk : k_s5;
		a_s6    <= a_s5;
		on_s6   <= on_s5;

		// s7: side decision and partial products
		tag_s7.side  <= (tolx >= cmag_s6) ? kpos_s6 : !cneg_s6;
		tag_s7.coinc <= on_s6 || (cmag_s6 < tolx);
		tag_s7.cneg  <= cneg_s6;
		tag_s7.qok   <= (a_s6 != '0);
		tag_s7.kneg  <= kneg_s6;
		tag_s7.kpos  <= kpos_s6;
		tag_s7.kmag  <= kmag_s6;
		tag_s7.a     <= a_s6;
		pp_hh_s7 <= (2*KH)'(kpad[2*KH-1:KH]) * (2*KH)'(kpad[2*KH-1:KH]);
		pp_hl_s7 <= (2*KH)'(kpad[2*KH-1:KH]) * (2*KH)'(kpad[KH-1:0]);
		pp_ll_s7 <= (2*KH)'(kpad[KH-1:0]) * (2*KH)'(kpad[KH-1:0]);
		ac0_s7   <= (A_W+CCH)'(a_s6) * (A_W+CCH)'(cpad[CCH-1:0]);
		ac1_s7   <= (A_W+CCH)'(a_s6) * (A_W+CCH)'(cpad[2*CCH-1:CCH]);
		ac2_s7   <= (A_W+CCH)'(a_s6) * (A_W+CCH)'(cpad[3*CCH-1:2*CCH]);

		// s8: combine partial products into k^2 and a*|c|
		k2_s8  <= (QW'(pp_hh_s7) << (2*KH)) + (QW'(pp_hl_s7) << (KH+1)) + QW'(pp_ll_s7);
		ac_s8  <= (QW'(ac2_s7) << (2*CCH)) + (QW'(ac1_s7) << CCH) + QW'(ac0_s7);
		tag_s8 <= tag_s7;

		// s9: discriminant
		quad_s9 <= tag_s8.cneg ? qsum : qdiff[QW-1:0];
		tag_s9  <= tag_nx;
	end

	assign out_vld = vld_q[FRONT_STAGES-1];
	assign quad    = quad_s9;
	assign tag     = tag_s9;

endmodule

### hw/rtl/zcsd_sqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit per stage, with sideband carried along.
// Depends on zcsd_pkg.
module zcsd_sqrt import zcsd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  logic [QW-1:0]     quad,
	input  zcsd_tag_t         in_tag,
	output logic              out_vld,
	output logic [SQ_W-1:0]   root,
	output zcsd_tag_t         out_tag
);

	logic              vld_s  [SQ_W+1];
	logic [QW-1:0]     rad_s  [SQ_W+1];
	logic [REM_W-1:0]  rem_s  [SQ_W+1];
	logic [SQ_W-1:0]   root_s [SQ_W+1];
	zcsd_tag_t         tag_s  [SQ_W+1];

	assign vld_s[0]  = in_vld;
	assign rad_s[0]  = quad;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign tag_s[0]  = in_tag;

	for (genvar i = 0; i < SQ_W; i++) begin : g_step
		logic [REM_W-1:0] remsh;
		logic [REM_W-1:0] trial;
		logic             take;

		// bring in the next radicand bit pair, try root*4+1
		assign remsh = {rem_s[i][REM_W-3:0], rad_s[i][QW-1:QW-2]};
		assign trial = {1'b0, root_s[i], 2'b01};
		assign take  = remsh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			rad_s[i+1]  <= {rad_s[i][QW-3:0], 2'b00};
			rem_s[i+1]  <= take ? remsh - trial : remsh;
			root_s[i+1] <= {root_s[i][SQ_W-2:0], take};
			tag_s[i+1]  <= tag_s[i];
		end
	end

	assign out_vld = vld_s[SQ_W];
	assign root    = root_s[SQ_W];
	assign out_tag = tag_s[SQ_W];

endmodule

### hw/rtl/zcsd_div.sv
`timescale 1ns / 1ps
// Numerator selection and pipelined restoring divide by |dir|^2, one quotient bit per stage.
// Depends on zcsd_pkg.
module zcsd_div import zcsd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  logic [SQ_W-1:0]   root,
	input  zcsd_tag_t         in_tag,
	output logic              out_vld,
	output logic              side,
	output logic              hit,
	output logic [DIST_W-1:0] hit_dist
);

	logic [NUM_W-1:0]  kmx, sqx, sum, sqmk, kmsq, num;
	logic              sq_ge_k, hit_c;
	logic              vld_s1, vld_s2;
	logic [NUM_W-1:0]  num_s1;
	logic              hit_s1, side_s1;
	logic [A_W-1:0]    a_s1;
	logic [DVD_W-1:0]  dvd;
	logic [HI_W-1:0]   hi;

	logic              vld_s  [DIST_W+1];
	logic [DREM_W-1:0] rem_s  [DIST_W+1];
	logic [DIST_W-1:0] low_s  [DIST_W+1];
	logic [DIST_W-1:0] quo_s  [DIST_W+1];
	logic [A_W-1:0]    a_s    [DIST_W+1];
	logic              sat_s  [DIST_W+1];
	logic              hit_s  [DIST_W+1];
	logic              side_s [DIST_W+1];

	// pick the forward root
	assign kmx     = NUM_W'(in_tag.kmag);
	assign sqx     = NUM_W'(root);
	assign sum     = kmx + sqx;
	assign sqmk    = sqx - kmx;
	assign kmsq    = kmx - sqx;
	assign sq_ge_k = sqx >= kmx;

	always_comb begin
		if (in_tag.coinc) begin
			hit_c = in_tag.kneg;
			num   = sum;
		end else if (in_tag.cneg) begin
			hit_c = 1'b1;
			num   = in_tag.kneg ? sum : (sq_ge_k ? sqmk : '0);
		end else begin
			hit_c = !in_tag.kpos && (kmx >= sqx);
			num   = kmsq;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	assign dvd = {num_s1, {DIR_FRAC_BITS{1'b0}}};
	assign hi  = dvd[DVD_W-1:DIST_W];

	always_ff @(posedge clk) begin
		// s1: numerator and hit
		num_s1  <= num;
		hit_s1  <= hit_c && in_tag.qok;
		side_s1 <= in_tag.side;
		a_s1    <= in_tag.a;

		// s2: saturation check, seed the remainder with the upper dividend
		sat_s[0]  <= hi >= HI_W'(a_s1);
		rem_s[0]  <= hi[DREM_W-1:0];
		low_s[0]  <= dvd[DIST_W-1:0];
		quo_s[0]  <= '0;
		a_s[0]    <= a_s1;
		hit_s[0]  <= hit_s1;
		side_s[0] <= side_s1;
	end

	assign vld_s[0] = vld_s2;

	for (genvar i = 0; i < DIST_W; i++) begin : g_step
		logic [DREM_W-1:0] remsh;
		logic              take;

		// shift in the next dividend bit, subtract when it fits
		assign remsh = {rem_s[i][DREM_W-2:0], low_s[i][DIST_W-1]};
		assign take  = remsh >= DREM_W'(a_s[i]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[i+1]  <= take ? remsh - DREM_W'(a_s[i]) : remsh;
			low_s[i+1]  <= {low_s[i][DIST_W-2:0], 1'b0};
			quo_s[i+1]  <= {quo_s[i][DIST_W-2:0], take};
			a_s[i+1]    <= a_s[i];
			sat_s[i+1]  <= sat_s[i];
			hit_s[i+1]  <= hit_s[i];
			side_s[i+1] <= side_s[i];
		end
	end

	assign out_vld  = vld_s[DIST_W];
	assign side     = side_s[DIST_W];
	assign hit      = hit_s[DIST_W];
	assign hit_dist = !hit_s[DIST_W] ? '0 : (sat_s[DIST_W] ? '1 : quo_s[DIST_W]);

endmodule

### hw/rtl/zcsd_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the z-cylinder side/distance unit, bound to the top level.
// Depends on zcsd_pkg and zcylinder_side_and_distance_unit.
module zcsd_checker import zcsd_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    start,
	input logic                    busy,
	input logic signed [DIR_W-1:0] dir_x,
	input logic signed [DIR_W-1:0] dir_y,
	input logic                    done,
	input logic                    hit,
	input logic [DIST_W-1:0]       hit_distance
);

	// every accepted request yields a strobe after the fixed latency
	a_req_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("accepted request gave no result");

	// no strobe without a request
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##LATENCY !done)
		else $error("result without a request");

	// a zero direction never hits
	a_zero_dir: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && dir_x == '0 && dir_y == '0) |-> ##LATENCY (done && !hit))
		else $error("zero direction reported a hit");

	// a miss carries zero distance
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !hit) |-> (hit_distance == '0))
		else $error("miss with nonzero distance");

endmodule

bind zcylinder_side_and_distance_unit zcsd_checker u_zcsd_checker (.*);

### dv/zcylinder_side_and_distance_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the z-cylinder side and distance unit.
// Depends on zcsd_pkg and zcylinder_side_and_distance_unit; it predicts each result
// with exact wide integer arithmetic and checks every done strobe against it.
module zcylinder_side_and_distance_unit_tb;
	import zcsd_pkg::*;

	typedef struct {
		logic              side;
		logic              hit;
		logic [DIST_W-1:0] hit_dist;
	} cyl_result_t;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic                    cfg_we;
	logic [IDX_W-1:0]        cfg_index;
	logic [CFG_W-1:0]        cfg_wdata;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic signed [DIR_W-1:0] dir_x;
	logic signed [DIR_W-1:0] dir_y;
	logic                    on_surface;
	logic                    done;
	logic                    side_positive;
	logic                    hit;
	logic [DIST_W-1:0]       hit_distance;

	// Local copy of the cylinder registers
	logic signed [127:0] cyl_cx;
	logic signed [127:0] cyl_cy;
	logic signed [127:0] cyl_rad;
	logic signed [127:0] cyl_tol;

	cyl_result_t pending_results[$];
	int          mismatches;

	zcylinder_side_and_distance_unit uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.pos_x(pos_x), .pos_y(pos_y), .dir_x(dir_x), .dir_y(dir_y),
		.on_surface(on_surface), .done(done), .side_positive(side_positive),
		.hit(hit), .hit_distance(hit_distance)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(20ns * 400000);
		$display("Test completed with failures");
		$finish;
	end

	// Floor of the square root of a nonnegative value below 2^126
	function automatic logic signed [127:0] floor_sqrt(input logic signed [127:0] x);
		logic signed [127:0] root;
		logic [129:0]        trial;
		root = 0;
		for (int i = 63; i >= 0; i--) begin
			trial = 130'(root) | (130'(1) << i);
			if (trial * trial <= 130'(x))
				root = 128'(trial);
		end
		return root;
	endfunction

	function automatic cyl_result_t predict_cylinder(input logic signed [POS_W-1:0] px,
			input logic signed [POS_W-1:0] py, input logic signed [DIR_W-1:0] ux_in,
			input logic signed [DIR_W-1:0] uy_in, input logic onsurf);
		logic signed [127:0] dx, dy, ux, uy, c, cmag, k, kmag, a, quad, sq, num, quo;
		logic                cneg;
		logic                found;
		cyl_result_t         r;
		dx = 128'(px) - cyl_cx;
		dy = 128'(py) - cyl_cy;
		ux = ux_in;
		uy = uy_in;
		c = dx * dx + dy * dy - cyl_rad * cyl_rad;
		cneg = c < 0;
		cmag = cneg ? -c : c;
		k = dx * ux + dy * uy;
		kmag = (k < 0) ? -k : k;
		a = ux * ux + uy * uy;
		r.side = (cmag > cyl_tol) ? !cneg : (k > 0);
		found = 1'b0;
		num = 0;
		if (a != 0) begin
			quad = k * k - a * c;
			if (quad >= 0) begin
				sq = floor_sqrt(quad);
				// coincident start leaves only when heading inward
				if (onsurf || cmag < cyl_tol) begin
					if (k < 0) begin
						num = kmag + sq;
						found = 1'b1;
					end
				end else if (cneg) begin
					num = (k < 0) ? kmag + sq : ((sq >= kmag) ? sq - kmag : 0);
					found = 1'b1;
				end else if (k <= 0 && kmag >= sq) begin
					num = kmag - sq;
					found = 1'b1;
				end
			end
		end
		r.hit = found;
		r.hit_dist = '0;
		if (found) begin
			quo = (num <<< DIR_FRAC_BITS) / a;
			r.hit_dist = (quo > 128'sh0FFFF_FFFF) ? '1 : quo[DIST_W-1:0];
		end
		return r;
	endfunction

	// Predict on each accepted request, check each strobed result
	always @(posedge clk) begin
		cyl_result_t want;
		if (done) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: side %0b hit %0b dist %08h",
						side_positive, hit, hit_distance);
			end else begin
				want = pending_results.pop_front();
				if (want.side !== side_positive || want.hit !== hit
						|| want.hit_dist !== hit_distance) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected side %0b hit %0b dist %08h, got %0b %0b %08h",
							want.side, want.hit, want.hit_dist, side_positive, hit,
							hit_distance);
				end
			end
		end
		if (arst_n && start && !busy)
			pending_results.push_back(predict_cylinder(pos_x, pos_y, dir_x, dir_y, on_surface));
	end

	// Hold start high until the request is taken; leave it high for a following request
	task automatic send_particle(input logic signed [POS_W-1:0] px,
			input logic signed [POS_W-1:0] py, input logic signed [DIR_W-1:0] ux,
			input logic signed [DIR_W-1:0] uy, input logic onsurf);
		start <= 1'b1;
		pos_x <= px;
		pos_y <= py;
		dir_x <= ux;
		dir_y <= uy;
		on_surface <= onsurf;
		@(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic idle_cycles(input int n);
		start <= 1'b0;
		repeat (n)
			@(posedge clk);
	endtask

	// Drain every outstanding request, then let the pipeline settle
	task automatic drain_pipeline();
		idle_cycles(1);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
	endtask

	task automatic write_reg(input zcsd_reg_t idx, input logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_CENTER_X: cyl_cx = 128'(signed'(value));
			REG_CENTER_Y: cyl_cy = 128'(signed'(value));
			REG_RADIUS:   cyl_rad = {97'b0, value[RAD_W-1:0]};
			REG_TOL:      cyl_tol = {96'b0, value};
			default:      ;
		endcase
	endtask

	task automatic set_cylinder(input logic [31:0] cx, input logic [31:0] cy,
			input logic [31:0] rad, input logic [31:0] tol);
		drain_pipeline();
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_RADIUS, rad);
		write_reg(REG_TOL, tol);
		@(posedge clk);
	endtask

	// Directed cases under the reset geometry: unit circle at the origin
	task automatic test_directed();
		send_particle(32'sh0002_0000, 0, -16384, 0, 1'b0);     // outside, head-on
		send_particle(32'sh0002_0000, 0, 16384, 0, 1'b0);      // outside, moving away
		send_particle(0, 0, 0, 16384, 1'b0);                   // inside
		send_particle(32'sh0001_0000, 0, 16384, 0, 1'b0);      // on surface, leaving
		send_particle(32'sh0001_0000, 0, -16384, 0, 1'b0);     // on surface, entering
		send_particle(32'sh0001_0000, 0, 0, 16384, 1'b1);      // on surface, tangent
		send_particle(0, 32'sh0002_0000, 16384, 0, 1'b0);      // miss
		send_particle(-32'sh0002_0000, 32'sh0001_0000, 16384, 0, 1'b0); // grazing
		send_particle(32'sh0000_8000, 0, 0, 0, 1'b0);          // zero direction
		send_particle(0, 32'sh0000_4000, -16384, 0, 1'b1);     // inside, flagged on surface
		send_particle(-32'sh7530_0000, 0, 1, 0, 1'b0);         // far away, saturates
		send_particle(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, -16384, -16384, 1'b0);
		send_particle(32'sh8000_0000, 32'sh8000_0000, 16384, 16384, 1'b0);
		send_particle(32'sh7FFF_FFFF, 32'sh8000_0000, -32768, 32767, 1'b1);
		send_particle(32'sh8000_0000, 32'sh7FFF_FFFF, 32767, -32768, 1'b0);
		send_particle(32'sh0000_B505, 32'sh0000_B505, -11585, -11585, 1'b0);
		send_particle(32'sh0000_B505, 32'sh0000_B504, 11585, 11585, 1'b0);
		send_particle(32'sh0001_0001, 0, -16384, 1, 1'b0);
	endtask

	function automatic longint rand_span(input longint lim);
		if (lim <= 0)
			return 0;
		return longint'({$urandom, $urandom} % (2 * lim + 1)) - lim;
	endfunction

	// Bursts of particles placed near the current surface, inside it, within three radii or anywhere
	task automatic test_random_particles(input int count);
		longint rr, ox, oy;
		int     burst;
		logic signed [DIR_W-1:0] ux, uy;
		burst = $urandom_range(1, 30);
		for (int n = 0; n < count; n++) begin
			rr = longint'(cyl_rad);
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					ox = rand_span(rr);
					oy = longint'(floor_sqrt(128'(rr * rr - ox * ox)));
					if ($urandom_range(0, 1))
						oy = -oy;
					oy += $urandom_range(0, 6) - 3;
				end
				4, 5: begin
					ox = rand_span(rr / 2);
					oy = rand_span(rr / 2);
				end
				6, 7: begin
					ox = rand_span(3 * rr);
					oy = rand_span(3 * rr);
				end
				default: begin
					ox = longint'(signed'($urandom)) - longint'(cyl_cx);
					oy = longint'(signed'($urandom)) - longint'(cyl_cy);
				end
			endcase
			case ($urandom_range(0, 7))
				0: begin ux = $urandom; uy = $urandom; end
				1: begin ux = 0; uy = 0; end
				2: begin ux = $urandom_range(0, 1) ? 16384 : -16384; uy = 0; end
				3: begin ux = 0; uy = $urandom_range(0, 1) ? 16384 : -16384; end
				default: begin
					ux = $urandom_range(0, 32768) - 16384;
					uy = $urandom_range(0, 32768) - 16384;
				end
			endcase
			send_particle(32'(longint'(cyl_cx) + ox), 32'(longint'(cyl_cy) + oy), ux, uy,
				$urandom_range(0, 4) == 0);
			// close the burst with a gap, sometimes none
			if (--burst == 0) begin
				burst = $urandom_range(1, 30);
				if ($urandom_range(0, 2) != 0)
					idle_cycles($urandom_range(1, 8));
			end
		end
	endtask

	task automatic test_geometries();
		test_random_particles(220);
		set_cylinder(32'sh03E8_8000, -32'sh012C_0000, 32'h0005_0000, 32'd100000);
		test_random_particles(220);
		set_cylinder(32'sh7FFF_FFFF, 32'sh8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		test_random_particles(200);
		set_cylinder(32'sh8000_0000, 32'sh7FFF_FFFF, 32'h0000_0000, 32'h0000_0000);
		test_random_particles(160);
		set_cylinder($urandom, $urandom, $urandom_range(0, 32'h0100_0000), $urandom);
		test_random_particles(200);
		set_cylinder(32'sh0000_0040, -32'sh0000_0040, 32'h0000_0003, 32'd4);
		test_random_particles(180);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_CENTER_X;
		cfg_wdata = '0;
		pos_x = '0;
		pos_y = '0;
		dir_x = '0;
		dir_y = '0;
		on_surface = 1'b0;
		mismatches = 0;
		cyl_cx = 0;
		cyl_cy = 0;
		cyl_rad = 65536;
		cyl_tol = 4295;
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_geometries();

		drain_pipeline();
		repeat (LATENCY + 10)
			@(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

### sim.f
hw/rtl/zcsd_pkg.sv
hw/rtl/zcsd_front.sv
hw/rtl/zcsd_sqrt.sv
hw/rtl/zcsd_div.sv
hw/rtl/zcylinder_side_and_distance_unit.sv
hw/rtl/zcsd_checker.sv
dv/zcylinder_side_and_distance_unit_tb.sv
